// ===== src/rdc_pkg.sv =====
// Shared constants and types for the radial distortion correction unit.
// Fraction formats, internal word widths, pipeline latency and register indexes.
// No dependencies.
package rdc_pkg;

  localparam int COORD_FRAC  = 16;
  localparam int TILT_FRAC   = 30;
  localparam int QUAD_FRAC   = 40;
  localparam int RADIAL_FRAC = 48;
  localparam int QUART_FRAC  = 72;

  localparam int XF_RAD = RADIAL_FRAC + 3 * COORD_FRAC;
  localparam int XFRAC  = (COORD_FRAC > XF_RAD) ? COORD_FRAC : XF_RAD;
  localparam int ZF_TLT = TILT_FRAC + COORD_FRAC;
  localparam int ZF_QD  = QUAD_FRAC + 2 * COORD_FRAC;
  localparam int ZF_QT  = QUART_FRAC + 4 * COORD_FRAC;
  localparam int ZF_A   = (COORD_FRAC > ZF_TLT) ? COORD_FRAC : ZF_TLT;
  localparam int ZF_B   = (ZF_QD > ZF_QT) ? ZF_QD : ZF_QT;
  localparam int ZFRAC  = (ZF_A > ZF_B) ? ZF_A : ZF_B;

  localparam int SH_X0 = XFRAC - COORD_FRAC;
  localparam int SH_Z0 = ZFRAC - COORD_FRAC;
  localparam int SH_ZT = ZFRAC - TILT_FRAC - COORD_FRAC;
  localparam int SH_ZA = ZFRAC - QUAD_FRAC - 2 * COORD_FRAC;
  localparam int SH_ZB = ZFRAC - QUART_FRAC - 4 * COORD_FRAC;

  // word widths: split point, tilt sum, squared radius, products
  localparam int RLO = 33;
  localparam int TW  = 65;
  localparam int R2W = 130;
  localparam int ARW = 98;
  localparam int RXW = 131;
  localparam int BQW = 163;

  localparam int XW_A = 32 + SH_X0;
  localparam int XW   = ((XW_A > RXW) ? XW_A : RXW) + 2;

  localparam int ZW_A = 32 + SH_Z0;
  localparam int ZW_B = TW + SH_ZT;
  localparam int ZW_C = ARW + SH_ZA;
  localparam int ZW_D = BQW + SH_ZB;
  localparam int ZW_AB = (ZW_A > ZW_B) ? ZW_A : ZW_B;
  localparam int ZW_CD = (ZW_C > ZW_D) ? ZW_C : ZW_D;
  localparam int ZW    = ((ZW_AB > ZW_CD) ? ZW_AB : ZW_CD) + 3;

  localparam int LATENCY = 9;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_CENTRE_X    = 3'd0,
    REG_CENTRE_Y    = 3'd1,
    REG_QUAD_COEF   = 3'd2,
    REG_QUART_COEF  = 3'd3,
    REG_RADIAL_COEF = 3'd4,
    REG_TILT_X      = 3'd5,
    REG_TILT_Y      = 3'd6
  } cfg_reg_t;

endpackage

// ===== src/radial_distortion_correct_unit.sv =====
// Radial distortion correction unit: nine-stage multiplier pipeline with config registers.
// Depends on rdc_pkg for fraction formats, widths and register indexes.
//
// Usage:
//   Input channel: drive raw_x, raw_y, raw_z, last_grain and pulse start. A word is
//   taken at every rising edge with start high and busy low; busy stays low, so a
//   new point may enter in every cycle.
//   Result channel: done is high for one cycle with corr_x, corr_y, corr_z,
//   saturated and last_out. Results leave in input order. The receiver cannot stall;
//   there is no backpressure.
//   Throughput: one point per cycle, set by the fully pipelined 33x33 multipliers;
//   r squared, R*dx*r and B*r^2 are split into partial products summed a stage later.
//   Config channel: cfg_valid with cfg_index and cfg_data; cfg_ready is always high.
//   Index 0..6 selects centre_x, centre_y, quad_coef, quart_coef, radial_coef,
//   tilt_x, tilt_y; other indexes are ignored. Write only while no point is in flight.
//   Reset: rst clears all config registers to zero and drops all words in flight;
//   done then stays low until a point taken after reset has passed every stage.
//   Results are rounded to nearest (ties up) and clip to 32 bits with saturated set.
module radial_distortion_correct_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] raw_x,
  input  logic signed [31:0] raw_y,
  input  logic signed [31:0] raw_z,
  input  logic               last_grain,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] corr_x,
  output logic signed [31:0] corr_y,
  output logic signed [31:0] corr_z,
  output logic               saturated,
  output logic               last_out
);

  localparam int XW  = rdc_pkg::XW;
  localparam int ZW  = rdc_pkg::ZW;
  localparam int RLO = rdc_pkg::RLO;
  localparam int XQ  = XW - rdc_pkg::SH_X0;
  localparam int ZQ  = ZW - rdc_pkg::SH_Z0;

  logic signed [31:0] centre_x, centre_y, quad_coef, quart_coef;
  logic signed [31:0] radial_coef, tilt_x, tilt_y;

  logic [8:1] vld;
  logic [8:1] lst;

  logic signed [31:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;
  logic signed [31:0] x_s4, y_s4, x_s5, y_s5;
  logic signed [32:0] dx_s1, dy_s1;
  logic signed [63:0] tx_s1, ty_s1;
  logic [63:0]        dxx_s2, dyy_s2;
  logic signed [64:0] rdx_s2, rdy_s2, rdx_s3, rdy_s3;
  logic signed [rdc_pkg::TW-1:0] ts_s2, ts_s3;
  logic [64:0]        r_s3;

  logic [63:0]        rhh_s4;
  logic [64:0]        rhl_s4;
  logic [65:0]        rll_s4;
  logic signed [64:0] arh_s4, xhh_s4, yhh_s4;
  logic signed [65:0] arl_s4, xhl_s4, yhl_s4;
  logic signed [66:0] xlh_s4, ylh_s4;
  logic signed [67:0] xll_s4, yll_s4;
  logic signed [ZW-1:0] zacc_s4, zacc_s5, zacc_s6, zacc_s7, az_s8;

  logic [rdc_pkg::R2W-1:0]        r2_s5;
  logic signed [rdc_pkg::ARW-1:0] ar_s5;
  logic signed [rdc_pkg::RXW-1:0] rx_s5, ry_s5;

  logic signed [65:0] bp0_s6, bp1_s6, bp2_s6, bp3_s6;
  logic signed [XW-1:0] ax_s6, ay_s6, ax_s7, ay_s7, ax_s8, ay_s8;
  logic signed [rdc_pkg::BQW-1:0] bq_s7;

  logic signed [XW-1:0] xb, yb;
  logic signed [ZW-1:0] zb;
  logic signed [XQ-1:0] xq, yq;
  logic signed [ZQ-1:0] zq;
  logic x_fit, y_fit, z_fit;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x    <= '0;
      centre_y    <= '0;
      quad_coef   <= '0;
      quart_coef  <= '0;
      radial_coef <= '0;
      tilt_x      <= '0;
      tilt_y      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rdc_pkg::cfg_reg_t'(cfg_index))
        rdc_pkg::REG_CENTRE_X:    centre_x    <= $signed(cfg_data);
        rdc_pkg::REG_CENTRE_Y:    centre_y    <= $signed(cfg_data);
        rdc_pkg::REG_QUAD_COEF:   quad_coef   <= $signed(cfg_data);
        rdc_pkg::REG_QUART_COEF:  quart_coef  <= $signed(cfg_data);
        rdc_pkg::REG_RADIAL_COEF: radial_coef <= $signed(cfg_data);
        rdc_pkg::REG_TILT_X:      tilt_x      <= $signed(cfg_data);
        rdc_pkg::REG_TILT_Y:      tilt_y      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[7:1], start & ~busy};
      done <= vld[8];
    end
  end

  always_ff @(posedge clk) begin
    lst <= {lst[7:1], last_grain};

    // offsets and tilt products
    x_s1  <= raw_x;
    y_s1  <= raw_y;
    z_s1  <= raw_z;
    dx_s1 <= 33'(raw_x) - 33'(centre_x);
    dy_s1 <= 33'(raw_y) - 33'(centre_y);
    tx_s1 <= 64'(tilt_x) * 64'(raw_x);
    ty_s1 <= 64'(tilt_y) * 64'(raw_y);

    // squares and radial coefficient times offset
    x_s2   <= x_s1;
    y_s2   <= y_s1;
    z_s2   <= z_s1;
    dxx_s2 <= 64'(dx_s1 * dx_s1);
    dyy_s2 <= 64'(dy_s1 * dy_s1);
    rdx_s2 <= 65'(radial_coef) * 65'(dx_s1);
    rdy_s2 <= 65'(radial_coef) * 65'(dy_s1);
    ts_s2  <= rdc_pkg::TW'(tx_s1) + rdc_pkg::TW'(ty_s1);

    // squared radius
    x_s3   <= x_s2;
    y_s3   <= y_s2;
    z_s3   <= z_s2;
    r_s3   <= 65'(dxx_s2) + 65'(dyy_s2);
    rdx_s3 <= rdx_s2;
    rdy_s3 <= rdy_s2;
    ts_s3  <= ts_s2;

    // partial products over the radius split into high and low halves
    x_s4    <= x_s3;
    y_s4    <= y_s3;
    rhh_s4  <= 64'(r_s3[64:RLO]) * 64'(r_s3[64:RLO]);
    rhl_s4  <= 65'(r_s3[64:RLO]) * 65'(r_s3[RLO-1:0]);
    rll_s4  <= 66'(r_s3[RLO-1:0]) * 66'(r_s3[RLO-1:0]);
    arh_s4  <= 65'(quad_coef) * $signed({1'b0, r_s3[64:RLO]});
    arl_s4  <= 66'(quad_coef) * $signed({1'b0, r_s3[RLO-1:0]});
    xhh_s4  <= 65'($signed(rdx_s3[64:RLO])) * 65'($signed({1'b0, r_s3[64:RLO]}));
    xhl_s4  <= 66'($signed(rdx_s3[64:RLO])) * 66'($signed({1'b0, r_s3[RLO-1:0]}));
    xlh_s4  <= 67'($signed({1'b0, rdx_s3[RLO-1:0]})) * 67'($signed({1'b0, r_s3[64:RLO]}));
    xll_s4  <= 68'($signed({1'b0, rdx_s3[RLO-1:0]})) * 68'($signed({1'b0, r_s3[RLO-1:0]}));
    yhh_s4  <= 65'($signed(rdy_s3[64:RLO])) * 65'($signed({1'b0, r_s3[64:RLO]}));
    yhl_s4  <= 66'($signed(rdy_s3[64:RLO])) * 66'($signed({1'b0, r_s3[RLO-1:0]}));
    ylh_s4  <= 67'($signed({1'b0, rdy_s3[RLO-1:0]})) * 67'($signed({1'b0, r_s3[64:RLO]}));
    yll_s4  <= 68'($signed({1'b0, rdy_s3[RLO-1:0]})) * 68'($signed({1'b0, r_s3[RLO-1:0]}));
    zacc_s4 <= (ZW'(z_s3) <<< rdc_pkg::SH_Z0) + (ZW'(ts_s3) <<< rdc_pkg::SH_ZT);

    // combine partial products
    x_s5    <= x_s4;
    y_s5    <= y_s4;
    r2_s5   <= (rdc_pkg::R2W'(rhh_s4) << (2 * RLO)) + (rdc_pkg::R2W'(rhl_s4) << (RLO + 1))
             + rdc_pkg::R2W'(rll_s4);
    ar_s5   <= (rdc_pkg::ARW'(arh_s4) <<< RLO) + rdc_pkg::ARW'(arl_s4);
    rx_s5   <= (rdc_pkg::RXW'(xhh_s4) <<< (2 * RLO)) + (rdc_pkg::RXW'(xhl_s4) <<< RLO)
             + (rdc_pkg::RXW'(xlh_s4) <<< RLO) + rdc_pkg::RXW'(xll_s4);
    ry_s5   <= (rdc_pkg::RXW'(yhh_s4) <<< (2 * RLO)) + (rdc_pkg::RXW'(yhl_s4) <<< RLO)
             + (rdc_pkg::RXW'(ylh_s4) <<< RLO) + rdc_pkg::RXW'(yll_s4);
    zacc_s5 <= zacc_s4;

    // quartic partial products, lateral sums, quadratic term
    bp0_s6  <= 66'(quart_coef) * $signed({1'b0, r2_s5[RLO-1:0]});
    bp1_s6  <= 66'(quart_coef) * $signed({1'b0, r2_s5[2*RLO-1:RLO]});
    bp2_s6  <= 66'(quart_coef) * $signed({1'b0, r2_s5[3*RLO-1:2*RLO]});
    bp3_s6  <= 66'(quart_coef) * $signed({1'b0, r2_s5[rdc_pkg::R2W-1:3*RLO]});
    ax_s6   <= (XW'(x_s5) <<< rdc_pkg::SH_X0) + XW'(rx_s5);
    ay_s6   <= (XW'(y_s5) <<< rdc_pkg::SH_X0) + XW'(ry_s5);
    zacc_s6 <= zacc_s5 - (ZW'(ar_s5) <<< rdc_pkg::SH_ZA);

    // quartic term
    bq_s7   <= (rdc_pkg::BQW'(bp3_s6) <<< (3 * RLO)) + (rdc_pkg::BQW'(bp2_s6) <<< (2 * RLO))
             + (rdc_pkg::BQW'(bp1_s6) <<< RLO) + rdc_pkg::BQW'(bp0_s6);
    ax_s7   <= ax_s6;
    ay_s7   <= ay_s6;
    zacc_s7 <= zacc_s6;

    az_s8 <= zacc_s7 - (ZW'(bq_s7) <<< rdc_pkg::SH_ZB);
    ax_s8 <= ax_s7;
    ay_s8 <= ay_s7;

    // round and clip
    corr_x    <= x_fit ? xq[31:0] : (xq[XQ-1] ? rdc_pkg::SAT_MIN : rdc_pkg::SAT_MAX);
    corr_y    <= y_fit ? yq[31:0] : (yq[XQ-1] ? rdc_pkg::SAT_MIN : rdc_pkg::SAT_MAX);
    corr_z    <= z_fit ? zq[31:0] : (zq[ZQ-1] ? rdc_pkg::SAT_MIN : rdc_pkg::SAT_MAX);
    saturated <= ~(x_fit & y_fit & z_fit);
    last_out  <= lst[8];
  end

  always_comb begin
    xb    = ax_s8 + (XW'(1) <<< (rdc_pkg::SH_X0 - 1));
    yb    = ay_s8 + (XW'(1) <<< (rdc_pkg::SH_X0 - 1));
    zb    = az_s8 + (ZW'(1) <<< (rdc_pkg::SH_Z0 - 1));
    xq    = xb[XW-1:rdc_pkg::SH_X0];
    yq    = yb[XW-1:rdc_pkg::SH_X0];
    zq    = zb[ZW-1:rdc_pkg::SH_Z0];
    x_fit = (&xq[XQ-1:31]) | ~(|xq[XQ-1:31]);
    y_fit = (&yq[XQ-1:31]) | ~(|yq[XQ-1:31]);
    z_fit = (&zq[ZQ-1:31]) | ~(|zq[ZQ-1:31]);
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(rdc_pkg::LATENCY) done)
    else $error("accepted point produced no result at fixed latency");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rdc_pkg::LATENCY))
    else $error("result without a matching accepted point");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (corr_x == rdc_pkg::SAT_MAX || corr_x == rdc_pkg::SAT_MIN ||
                             corr_y == rdc_pkg::SAT_MAX || corr_y == rdc_pkg::SAT_MIN ||
                             corr_z == rdc_pkg::SAT_MAX || corr_z == rdc_pkg::SAT_MIN))
    else $error("saturated flag set with no clipped coordinate");

endmodule

// ===== bench/tb_radial_distortion_correct_unit.sv =====
// Self-checking bench for radial_distortion_correct_unit: drives points, computes the
// corrected point at full width, and checks every result word in order.
// Depends on rdc_pkg (fraction shifts, saturation limits, register indexes) and the unit.
module tb_radial_distortion_correct_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rdc_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int WIDE = 384;

  typedef logic signed [WIDE-1:0] wide_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } point_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               sat;
    logic               last;
  } corr_t;

  typedef enum {SET_ZERO, SET_RANDOM, SET_EXTREME_HI, SET_EXTREME_LO, SET_ROUND_TIE} setting_kind_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] raw_x = '0;
  logic signed [31:0] raw_y = '0;
  logic signed [31:0] raw_z = '0;
  logic               last_grain = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               busy;
  logic               cfg_ready;
  logic               done;
  logic signed [31:0] corr_x;
  logic signed [31:0] corr_y;
  logic signed [31:0] corr_z;
  logic               saturated;
  logic               last_out;

  logic signed [31:0] ctr_x = '0;
  logic signed [31:0] ctr_y = '0;
  logic signed [31:0] quad_k = '0;
  logic signed [31:0] quart_k = '0;
  logic signed [31:0] radial_k = '0;
  logic signed [31:0] tilt_kx = '0;
  logic signed [31:0] tilt_ky = '0;

  point_t pending_points[$];
  corr_t  expected_corr[$];
  point_t drive_point;
  corr_t  predicted;
  corr_t  want;

  int idle_pct = 0;
  int mismatches = 0;
  int points_checked = 0;
  int settings_used = 0;
  int clipped_points = 0;

  setting_kind_t phase_kind[6] = '{SET_RANDOM, SET_RANDOM, SET_RANDOM,
                                   SET_EXTREME_HI, SET_EXTREME_LO, SET_RANDOM};
  int phase_idle[6] = '{0, 72, 7, 0, 72, 7};
  int phase_count[6] = '{150, 150, 150, 100, 100, 180};

  radial_distortion_correct_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z), .last_grain(last_grain),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .corr_x(corr_x), .corr_y(corr_y),
    .corr_z(corr_z), .saturated(saturated), .last_out(last_out)
  );

  always #6 clk = ~clk;

  function automatic logic [32:0] round_clip(wide_t v, int sh);
    wide_t half;
    wide_t q;
    half = wide_t'(1) <<< (sh - 1);
    q = (v + half) >>> sh;
    if (q > wide_t'(SAT_MAX)) return {1'b1, SAT_MAX};
    if (q < wide_t'(SAT_MIN)) return {1'b1, SAT_MIN};
    return {1'b0, q[31:0]};
  endfunction

  function automatic corr_t correct_point(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z, logic last);
    wide_t wx = wide_t'(x);
    wide_t wy = wide_t'(y);
    wide_t wz = wide_t'(z);
    wide_t dx, dy, rr, ax, ay, az;
    logic [32:0] rx, ry, rz;
    corr_t res;
    dx = wx - wide_t'(ctr_x);
    dy = wy - wide_t'(ctr_y);
    rr = dx * dx + dy * dy;
    ax = (wx <<< SH_X0) + wide_t'(radial_k) * dx * rr;
    ay = (wy <<< SH_X0) + wide_t'(radial_k) * dy * rr;
    az = (wz <<< SH_Z0)
         - ((wide_t'(quad_k) * rr) <<< SH_ZA)
         - ((wide_t'(quart_k) * rr * rr) <<< SH_ZB)
         + ((wide_t'(tilt_kx) * wx) <<< SH_ZT)
         + ((wide_t'(tilt_ky) * wy) <<< SH_ZT);
    rx = round_clip(ax, SH_X0);
    ry = round_clip(ay, SH_X0);
    rz = round_clip(az, SH_Z0);
    res.cx = rx[31:0];
    res.cy = ry[31:0];
    res.cz = rz[31:0];
    res.sat = rx[32] | ry[32] | rz[32];
    res.last = last;
    return res;
  endfunction

  function automatic logic signed [31:0] scaled_rand();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      default: return v >>> $urandom_range(31);
    endcase
  endfunction

  function automatic logic signed [31:0] coord_near(logic signed [31:0] ctr);
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(15))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2, 3, 4: return v;
      default: return ctr + (v >>> $urandom_range(24, 4));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 25) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_v);
    if (got !== exp_v) report_mismatch($sformatf("%s got %h want %h", name, got, exp_v));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTRE_X:    ctr_x = val;
      REG_CENTRE_Y:    ctr_y = val;
      REG_QUAD_COEF:   quad_k = val;
      REG_QUART_COEF:  quart_k = val;
      REG_RADIAL_COEF: radial_k = val;
      REG_TILT_X:      tilt_kx = val;
      REG_TILT_Y:      tilt_ky = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(setting_kind_t kind);
    logic signed [31:0] vals[7];
    for (int i = 0; i < 7; i++) begin
      case (kind)
        SET_RANDOM:     vals[i] = scaled_rand();
        SET_EXTREME_HI: vals[i] = SAT_MAX;
        SET_EXTREME_LO: vals[i] = SAT_MIN;
        default:        vals[i] = '0;
      endcase
    end
    case (kind)
      SET_EXTREME_HI: vals[REG_CENTRE_X] = SAT_MIN;
      SET_EXTREME_LO: vals[REG_CENTRE_X] = SAT_MAX;
      SET_ROUND_TIE: begin
        vals[REG_QUAD_COEF] = 32'sh0080_0000;
        vals[REG_RADIAL_COEF] = SAT_MIN;
      end
      default: ;
    endcase
    for (int i = 0; i < 7; i++) write_reg(cfg_reg_t'(i), vals[i]);
    write_reg(REG_NONE, $urandom);
    settings_used++;
  endtask

  task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic last);
    pending_points.push_back('{x: x, y: y, z: z, last: last});
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_points.size() != 0 || start || expected_corr.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted = correct_point(raw_x, raw_y, raw_z, last_grain);
        if (predicted.sat) clipped_points++;
        expected_corr.push_back(predicted);
      end
      if (!start || !busy) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drive_point = pending_points.pop_front();
          start <= 1'b1;
          raw_x <= drive_point.x;
          raw_y <= drive_point.y;
          raw_z <= drive_point.z;
          last_grain <= drive_point.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_corr.size() == 0) begin
        report_mismatch("result word with no point outstanding");
      end else begin
        want = expected_corr.pop_front();
        check_field("corr_x", corr_x, want.cx);
        check_field("corr_y", corr_y, want.cy);
        check_field("corr_z", corr_z, want.cz);
        check_field("saturated", 32'(saturated), 32'(want.sat));
        check_field("last_out", 32'(last_out), 32'(want.last));
        points_checked++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: pass-through
    settings_used++;
    add_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
    add_point(SAT_MAX, SAT_MAX, SAT_MAX, 1'b1);
    add_point(SAT_MIN, SAT_MIN, SAT_MIN, 1'b0);
    add_point(SAT_MAX, SAT_MIN, 32'sd0, 1'b1);
    add_point(SAT_MIN, SAT_MAX, -32'sd1, 1'b0);
    add_point(32'sd1, -32'sd1, 32'sd1, 1'b1);
    wait_drained();

    apply_settings(SET_EXTREME_HI);
    add_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
    add_point(SAT_MAX, SAT_MAX, SAT_MAX, 1'b1);
    add_point(SAT_MIN, SAT_MIN, SAT_MIN, 1'b1);
    add_point(SAT_MIN, SAT_MAX, 32'sd0, 1'b0);
    wait_drained();

    apply_settings(SET_EXTREME_LO);
    add_point(32'sd0, 32'sd0, 32'sd0, 1'b1);
    add_point(SAT_MAX, SAT_MAX, SAT_MAX, 1'b0);
    add_point(SAT_MIN, SAT_MIN, SAT_MIN, 1'b1);
    add_point(SAT_MAX, SAT_MIN, 32'sd0, 1'b0);
    wait_drained();

    apply_settings(SET_ROUND_TIE);
    add_point(32'sh0001_0000, 32'sd0, 32'sd0, 1'b0);
    add_point(-32'sh0001_0000, 32'sd0, 32'sh0001_0000, 1'b1);
    add_point(32'sd0, 32'sh0001_0000, 32'sd0, 1'b0);
    add_point(32'sd0, -32'sh0001_0000, -32'sd1, 1'b1);
    add_point(32'sh0000_8000, 32'sh0000_8000, 32'sd0, 1'b0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      apply_settings(phase_kind[p]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < phase_count[p]; n++) begin
        if (p == 2 && n == phase_count[p] / 2) wait_drained();
        add_point(coord_near(ctr_x), coord_near(ctr_y), coord_near(32'sd0),
                  $urandom_range(7) == 0);
      end
      wait_drained();
    end

    repeat (LATENCY + 4) @(posedge clk);
    $display("Checked %0d corrected points under %0d coefficient settings, %0d clipped.",
             points_checked, settings_used, clipped_points);
    $display("Sender gaps of 0, 7 and 72 percent; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
